// ===== rtl/rv64alu_pkg.sv =====
// ----------------------------------------------------------------------------
// RV64 register-register ALU package
// Shared widths, instruction field layout, opcode and funct codes, and the
// register file write request.
// ----------------------------------------------------------------------------
package rv64alu_pkg;

  localparam int unsigned XLEN         = 64;
  localparam int unsigned REG_IDX_W    = 5;
  localparam int unsigned RV_REG_COUNT = 32;

  // Command codes carried on the input tuser.
  localparam logic CMD_EXEC = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  // Major opcodes.
  localparam logic [6:0] OPC_OP   = 7'h33;
  localparam logic [6:0] OPC_OP32 = 7'h3B;

  // funct7 forms.
  localparam logic [6:0] F7_BASE = 7'b0000000;
  localparam logic [6:0] F7_ALT  = 7'b0100000;

  // funct3 codes.
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SRL  = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  // One request as held in the execute stage.
  typedef struct packed {
    logic                 cmd;
    logic [6:0]           opcode;
    logic [2:0]           funct3;
    logic [6:0]           funct7;
    logic [REG_IDX_W-1:0] dest_reg;
    logic [REG_IDX_W-1:0] src1_reg;
    logic [REG_IDX_W-1:0] src2_reg;
    logic [XLEN-1:0]      load_value;
  } instr_t;

  // Register file write request.
  typedef struct packed {
    logic                 en;
    logic [REG_IDX_W-1:0] idx;
    logic [XLEN-1:0]      data;
  } rf_wr_t;

endpackage

// ===== rtl/rv64alu_regfile.sv =====
// ----------------------------------------------------------------------------
// RV64 ALU register file
// Integer register memory with one write port and two registered read ports,
// per-entry valid bits so that every register reads as zero after reset, and
// a write-to-read bypass for a write landing on the same edge as a read.
// ----------------------------------------------------------------------------
module rv64alu_regfile #(
  parameter int unsigned REG_COUNT = rv64alu_pkg::RV_REG_COUNT
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  rd_en,
  input  logic [rv64alu_pkg::REG_IDX_W-1:0]     rd_idx_a,
  input  logic [rv64alu_pkg::REG_IDX_W-1:0]     rd_idx_b,
  input  rv64alu_pkg::rf_wr_t                   wr,
  output logic [rv64alu_pkg::XLEN-1:0]          rd_data_a,
  output logic [rv64alu_pkg::XLEN-1:0]          rd_data_b
);
  import rv64alu_pkg::*;

  localparam int unsigned IDX_W = $clog2(REG_COUNT);
  localparam logic [REG_IDX_W:0] COUNT_LIM = (REG_IDX_W + 1)'(REG_COUNT);

  logic [XLEN-1:0]      mem [REG_COUNT];
  logic [REG_COUNT-1:0] vld_r;
  logic [REG_COUNT-1:0] vld_nxt;

  logic [XLEN-1:0] rdat_a_r;
  logic [XLEN-1:0] rdat_b_r;
  logic [XLEN-1:0] byp_data_r;
  logic            hit_a_r;
  logic            hit_b_r;
  logic            inr_a_r;
  logic            inr_b_r;
  logic            val_a_r;
  logic            val_b_r;

  logic inr_a;
  logic inr_b;

  assign inr_a = {1'b0, rd_idx_a} < COUNT_LIM;
  assign inr_b = {1'b0, rd_idx_b} < COUNT_LIM;

  always_comb begin
    vld_nxt = vld_r;
    if (wr.en) begin
      vld_nxt[wr.idx[IDX_W-1:0]] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx[IDX_W-1:0]] <= wr.data;
    end
  end

  // Read side. A write on the capturing edge is not yet in the memory, so
  // its data is kept aside and selected after the read register.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdat_a_r   <= mem[rd_idx_a[IDX_W-1:0]];
      rdat_b_r   <= mem[rd_idx_b[IDX_W-1:0]];
      val_a_r    <= vld_r[rd_idx_a[IDX_W-1:0]];
      val_b_r    <= vld_r[rd_idx_b[IDX_W-1:0]];
      inr_a_r    <= inr_a;
      inr_b_r    <= inr_b;
      hit_a_r    <= wr.en && (wr.idx == rd_idx_a);
      hit_b_r    <= wr.en && (wr.idx == rd_idx_b);
      byp_data_r <= wr.data;
    end
  end

  assign rd_data_a = !inr_a_r ? '0 : hit_a_r ? byp_data_r : val_a_r ? rdat_a_r : '0;
  assign rd_data_b = !inr_b_r ? '0 : hit_b_r ? byp_data_r : val_b_r ? rdat_b_r : '0;

  // Register zero is never stored.
  a_no_x0_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> wr.idx != '0)
    else $error("register file write to x0");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |-> ({1'b0, wr.idx} < COUNT_LIM))
    else $error("register file write beyond the register count");

  a_write_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |=> vld_r[$past(wr.idx[IDX_W-1:0])])
    else $error("written register not marked valid");

endmodule

// ===== rtl/rv64alu_exec.sv =====
// ----------------------------------------------------------------------------
// RV64 ALU execute unit
// Decodes legality and computes the OP and OP-32 results, or passes the load
// value through for a load command.
// ----------------------------------------------------------------------------
module rv64alu_exec (
  input  rv64alu_pkg::instr_t          instr,
  input  logic [rv64alu_pkg::XLEN-1:0] src1,
  input  logic [rv64alu_pkg::XLEN-1:0] src2,
  output logic                         legal,
  output logic [rv64alu_pkg::XLEN-1:0] value
);
  import rv64alu_pkg::*;

  function automatic logic [XLEN-1:0] sext32(input logic [31:0] v);
    return {{(XLEN - 32){v[31]}}, v};
  endfunction

  logic            alt;
  logic            f7_ok;
  logic            alt_ok;
  logic [XLEN-1:0] sum;
  logic [5:0]      sh6;
  logic [4:0]      sh5;
  logic [31:0]     a32;
  logic [31:0]     sllw32;
  logic [31:0]     srlw32;
  logic [31:0]     sraw32;
  logic [XLEN-1:0] sra64;

  always_comb begin
    alt    = instr.funct7 == F7_ALT;
    f7_ok  = (instr.funct7 == F7_BASE) || alt;
    // The alternate form exists only for add/sub and the right shifts.
    alt_ok = !alt || (instr.funct3 == F3_ADD) || (instr.funct3 == F3_SRL);
    sum    = alt ? src1 - src2 : src1 + src2;
    sh6    = src2[5:0];
    sh5    = src2[4:0];
    a32    = src1[31:0];
    sllw32 = a32 << sh5;
    srlw32 = a32 >> sh5;
    sraw32 = 32'($signed(a32) >>> sh5);
    sra64  = XLEN'($signed(src1) >>> sh6);

    legal = 1'b0;
    value = '0;
    if (instr.cmd == CMD_LOAD) begin
      legal = 1'b1;
      value = instr.load_value;
    end else if (f7_ok && alt_ok) begin
      if (instr.opcode == OPC_OP) begin
        legal = 1'b1;
        unique case (instr.funct3)
          F3_ADD:  value = sum;
          F3_SLL:  value = src1 << sh6;
          F3_SLT:  value = {{(XLEN - 1){1'b0}}, $signed(src1) < $signed(src2)};
          F3_SLTU: value = {{(XLEN - 1){1'b0}}, src1 < src2};
          F3_XOR:  value = src1 ^ src2;
          F3_SRL:  value = alt ? sra64 : src1 >> sh6;
          F3_OR:   value = src1 | src2;
          default: value = src1 & src2;
        endcase
      end else if (instr.opcode == OPC_OP32) begin
        unique case (instr.funct3)
          F3_ADD: begin
            legal = 1'b1;
            value = sext32(sum[31:0]);
          end
          F3_SLL: begin
            legal = 1'b1;
            value = sext32(sllw32);
          end
          F3_SRL: begin
            legal = 1'b1;
            value = sext32(alt ? sraw32 : srlw32);
          end
          default: begin
            legal = 1'b0;
            value = '0;
          end
        endcase
      end
    end
  end

endmodule

// ===== rtl/rv64_register_register_alu.sv =====
// ----------------------------------------------------------------------------
// RV64I register-register ALU
// Executes OP and OP-32 instructions, or loads a value, against an integer
// register file with x0 fixed at zero, one request per cycle unless the output stalls.
// ----------------------------------------------------------------------------
// Each request on the input stream either executes one RV64I register-
// register instruction (add, sub, sll, slt, sltu, xor, srl, sra, or, and and
// the W forms addw, subw, sllw, srlw, sraw) or, when in_tuser is set, loads a
// 64-bit value straight into the destination register. Every request yields
// exactly one result. A request is taken every clock cycle unless the
// pipeline stalls: the accepting edge captures the request and reads both
// source registers out of the register file into its registered read ports,
// and the edge on which the execute stage advances loads the result register
// and writes the destination register, after which the result can be taken
// downstream. A result written on one edge is forwarded to a request
// read on that same edge, so back-to-back dependent instructions see the new
// value. The result register may wait on out_tready while the next request is
// already executing; the pipeline only stalls when both stages are full.
// Encodings the ISA does not define give illegal=1 and write nothing. W
// results are sign-extended from bit 31, and shift amounts come from the low
// 6 (or 5 for W forms) bits of the rs2 register value. When nothing is
// written, written_index and written_value are zero. All registers read as
// zero after reset; no clearing pass is needed.
// ----------------------------------------------------------------------------
module rv64_register_register_alu #(
  parameter int unsigned REG_COUNT = rv64alu_pkg::RV_REG_COUNT
) (
  input  logic        clk,
  input  logic        rst_n,
  // Request stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  // [6:0] opcode, [9:7] funct3, [16:10] funct7, [21:17] dest_reg,
  // [26:22] src1_reg, [31:27] src2_reg, [95:32] load_value.
  input  logic [95:0] in_tdata,
  // [0] cmd: 0 execute, 1 load.
  input  logic [0:0]  in_tuser,
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  // [4:0] written_index, [68:5] written_value, [71:69] zero.
  output logic [71:0] out_tdata,
  // [0] illegal, [1] written.
  output logic [1:0]  out_tuser
);
  import rv64alu_pkg::*;

  localparam logic [REG_IDX_W:0] COUNT_LIM = (REG_IDX_W + 1)'(REG_COUNT);

  // Input unpacking.
  instr_t in_instr;

  always_comb begin
    in_instr.cmd        = in_tuser[0];
    in_instr.opcode     = in_tdata[6:0];
    in_instr.funct3     = in_tdata[9:7];
    in_instr.funct7     = in_tdata[16:10];
    in_instr.dest_reg   = in_tdata[21:17];
    in_instr.src1_reg   = in_tdata[26:22];
    in_instr.src2_reg   = in_tdata[31:27];
    in_instr.load_value = in_tdata[95:32];
  end

  // Execute stage holding register and the result register.
  logic   s1_vld_r;
  logic   s1_vld_nxt;
  instr_t s1_instr_r;
  logic   out_vld_r;
  logic   out_vld_nxt;

  logic                 out_illegal_r;
  logic                 out_written_r;
  logic [REG_IDX_W-1:0] out_idx_r;
  logic [XLEN-1:0]      out_value_r;

  logic            in_acc;
  logic            s1_adv;
  logic [XLEN-1:0] src1_val;
  logic [XLEN-1:0] src2_val;
  logic            ex_legal;
  logic [XLEN-1:0] ex_value;
  logic            ex_written;
  rf_wr_t          rf_wr;

  // The execute stage moves on when the result register is empty or is
  // being drained this cycle; a new request may enter as it leaves.
  assign s1_adv    = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !s1_vld_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_acc) begin
      s1_vld_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_vld_nxt = 1'b0;
    end

    out_vld_nxt = out_vld_r;
    if (s1_adv) begin
      out_vld_nxt = 1'b1;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_instr_r <= in_instr;
    end
  end

  rv64alu_regfile #(
    .REG_COUNT (REG_COUNT)
  ) u_regfile (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (in_acc),
    .rd_idx_a  (in_instr.src1_reg),
    .rd_idx_b  (in_instr.src2_reg),
    .wr        (rf_wr),
    .rd_data_a (src1_val),
    .rd_data_b (src2_val)
  );

  rv64alu_exec u_exec (
    .instr (s1_instr_r),
    .src1  (src1_val),
    .src2  (src2_val),
    .legal (ex_legal),
    .value (ex_value)
  );

  // A write happens only for a legal request aimed at an existing register
  // other than x0.
  assign ex_written = ex_legal && (s1_instr_r.dest_reg != '0) &&
                      ({1'b0, s1_instr_r.dest_reg} < COUNT_LIM);

  always_comb begin
    rf_wr.en   = s1_adv && ex_written;
    rf_wr.idx  = s1_instr_r.dest_reg;
    rf_wr.data = ex_value;
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_illegal_r <= !ex_legal;
      out_written_r <= ex_written;
      out_idx_r     <= ex_written ? s1_instr_r.dest_reg : '0;
      out_value_r   <= ex_written ? ex_value : '0;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {3'b000, out_value_r, out_idx_r};
  assign out_tuser  = {out_written_r, out_illegal_r};

  // A register write always comes with a result entering the output.
  a_write_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    rf_wr.en |-> s1_adv)
    else $error("register write without a result");

  a_written_not_illegal: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tuser[0] && out_tuser[1]))
    else $error("result both illegal and written");

  a_no_write_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[1] |-> out_tdata == '0)
    else $error("result without a write carries nonzero fields");

  a_written_nonzero_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tdata[4:0] != '0)
    else $error("result reports a write to x0");

endmodule
